/* rtl/ntc_pkg.sv */
// shared types and constants for the ntc thermistor converter
// no dependencies; used by ntc_log_cell and the top level by scoped name
package ntc_pkg;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_LOW     = 2'd1;
    localparam logic [1:0] ST_HIGH    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SERIES  = 2'd0;
    localparam logic [1:0] CFG_NOMINAL = 2'd1;
    localparam logic [1:0] CFG_BETA    = 2'd2;

    localparam int CFG_W    = 20;
    localparam int SER_W    = 16;
    localparam int NOM_W    = 20;
    localparam int BETA_W   = 14;
    localparam int TEMP_W   = 15;

    // log2 datapath
    localparam int E_W       = 6;
    localparam int FRAC_W    = 24;
    localparam int LOG_W     = E_W + FRAC_W;
    localparam int MANT_W    = 32;
    localparam int LOG_STEPS = 24;

    // ln(2) in q.30
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // first divider: q = ln / beta, q.48, 42 quotient bits before saturation
    localparam int LN_W  = 30;
    localparam int D1_W  = LN_W + FRAC_W;
    localparam int Q1_W  = 42;

    // 1 / 298.15 k in q.48
    localparam longint unsigned INV_T0_FULL =
        ((64'd1 << 48) * 64'd100 + 64'd14907) / 64'd29815;
    localparam logic [39:0] INV_T0_Q48 = 40'(INV_T0_FULL);

    // second divider: tk = 100 * 2^48 / invT, 16 quotient bits
    localparam int IT_W = 43;
    localparam int D2_W = 55;
    localparam int Q2_W = 16;
    localparam logic [D2_W-1:0] TK_NUM = D2_W'(64'd100 << 48);

    localparam logic signed [16:0] K_OFFSET = 17'sd27315;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -15'sd5500;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'sd15000;
    localparam logic signed [16:0] C_MIN = -17'sd5500;
    localparam logic signed [16:0] C_MAX = 17'sd15000;

    // forced result carried down the pipe
    typedef struct packed {
        logic       forced;
        logic [1:0] st;
    } t_flags;

    typedef struct packed {
        logic [E_W-1:0] e_num;
        logic [E_W-1:0] e_den;
        t_flags         fl;
    } t_lg_side;

    typedef struct packed {
        logic   neg;
        logic   qovf;
        t_flags fl;
    } t_d1_side;

    typedef struct packed {
        logic   ovf;
        t_flags fl;
    } t_d2_side;

endpackage

/* rtl/ntc_log_cell.sv */
// one squaring step of the log2 fraction, for numerator and denominator
// depends on ntc_pkg
module ntc_log_cell #(
    parameter int PW = 15
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_v,
    input  logic [ntc_pkg::MANT_W-1:0] i_m_a,
    input  logic [ntc_pkg::FRAC_W-1:0] i_f_a,
    input  logic [ntc_pkg::MANT_W-1:0] i_m_b,
    input  logic [ntc_pkg::FRAC_W-1:0] i_f_b,
    input  logic [PW-1:0]             i_side,
    output logic                      o_v,
    output logic [ntc_pkg::MANT_W-1:0] o_m_a,
    output logic [ntc_pkg::FRAC_W-1:0] o_f_a,
    output logic [ntc_pkg::MANT_W-1:0] o_m_b,
    output logic [ntc_pkg::FRAC_W-1:0] o_f_b,
    output logic [PW-1:0]             o_side
);

    logic [2*ntc_pkg::MANT_W-1:0] w_sq_a, w_sq_b;
    logic [ntc_pkg::MANT_W:0]     w_t_a, w_t_b;
    logic [ntc_pkg::MANT_W-1:0]   n_m_a, n_m_b;
    logic [ntc_pkg::FRAC_W-1:0]   n_f_a, n_f_b;

    logic                         r_v;
    logic [ntc_pkg::MANT_W-1:0]   r_m_a, r_m_b;
    logic [ntc_pkg::FRAC_W-1:0]   r_f_a, r_f_b;
    logic [PW-1:0]                r_side;

    // square in q1.31, renormalize when it reaches 2.0
    always_comb begin
        w_sq_a = i_m_a * i_m_a;
        w_sq_b = i_m_b * i_m_b;
        w_t_a  = w_sq_a[2*ntc_pkg::MANT_W-1:ntc_pkg::MANT_W-1];
        w_t_b  = w_sq_b[2*ntc_pkg::MANT_W-1:ntc_pkg::MANT_W-1];
        n_m_a  = w_t_a[ntc_pkg::MANT_W] ? w_t_a[ntc_pkg::MANT_W:1]
                                        : w_t_a[ntc_pkg::MANT_W-1:0];
        n_m_b  = w_t_b[ntc_pkg::MANT_W] ? w_t_b[ntc_pkg::MANT_W:1]
                                        : w_t_b[ntc_pkg::MANT_W-1:0];
        n_f_a  = {i_f_a[ntc_pkg::FRAC_W-2:0], w_t_a[ntc_pkg::MANT_W]};
        n_f_b  = {i_f_b[ntc_pkg::FRAC_W-2:0], w_t_b[ntc_pkg::MANT_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_a  <= n_m_a;
            r_m_b  <= n_m_b;
            r_f_a  <= n_f_a;
            r_f_b  <= n_f_b;
            r_side <= i_side;
        end
    end

    assign o_v    = r_v;
    assign o_m_a  = r_m_a;
    assign o_f_a  = r_f_a;
    assign o_m_b  = r_m_b;
    assign o_f_b  = r_f_b;
    assign o_side = r_side;

endmodule

/* rtl/ntc_div_cell.sv */
// one restoring division step: one quotient bit per cell
// no package dependency
module ntc_div_cell #(
    parameter int DW = 14,
    parameter int QW = 42,
    parameter int PW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_v,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [QW-1:0] i_quot,
    input  logic [DW-1:0] i_div,
    input  logic [PW-1:0] i_side,
    output logic          o_v,
    output logic [DW-1:0] o_rem,
    output logic [QW-1:0] o_low,
    output logic [QW-1:0] o_quot,
    output logic [DW-1:0] o_div,
    output logic [PW-1:0] o_side
);

    logic [DW:0]   w_t;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [DW-1:0] n_rem;

    logic          r_v;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_low;
    logic [QW-1:0] r_quot;
    logic [DW-1:0] r_div;
    logic [PW-1:0] r_side;

    always_comb begin
        w_t    = {i_rem, i_low[QW-1]};
        w_ge   = w_t >= {1'b0, i_div};
        w_diff = w_t - {1'b0, i_div};
        n_rem  = w_ge ? w_diff[DW-1:0] : w_t[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_low  <= {i_low[QW-2:0], 1'b0};
            r_quot <= {i_quot[QW-2:0], w_ge};
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_v    = r_v;
    assign o_rem  = r_rem;
    assign o_low  = r_low;
    assign o_quot = r_quot;
    assign o_div  = r_div;
    assign o_side = r_side;

endmodule

/* rtl/ntc_thermistor_to_temperature_unit.sv */
// top level of the ntc thermistor converter: adc word in, temperature word out
// depends on ntc_pkg, ntc_log_cell, ntc_div_cell
//
// Converts one ADC word from a series-resistor / NTC divider into temperature
// in hundredths of a degree C using the beta equation. The block is a fully
// pipelined row of cells and takes one word every clock cycle while the skid
// stage holds no word; the row includes the 24 squaring cells of the log2 unit
// and the 42 + 16 bit-serial cells of the two restoring dividers. An output
// register plus a one-word skid stage sit at the end, so o_stall only rises
// after the output has been stalled with a second word arriving behind it.
// Registers: index 0 series resistance (ohms), 1 nominal resistance at 25 C
// (ohms), 2 beta (kelvin); write them only while no word is in flight. Status:
// 0 ok, 1 clamped to -55.00 C, 2 clamped to 150.00 C, 3 zero code (temperature
// reads 0). A zero beta acts as beta 1.
module ntc_thermistor_to_temperature_unit #(
    parameter int ADC_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_wr_en,
    input  logic [1:0]                         i_cfg_addr,
    input  logic [ntc_pkg::CFG_W-1:0]          i_cfg_wdata,
    // input word
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [ADC_BITS-1:0]                i_adc_code,
    // output word
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [ntc_pkg::TEMP_W-1:0]  o_temp_centi_c,
    output logic [1:0]                         o_status
);

    localparam int NUM_W  = ntc_pkg::SER_W + ADC_BITS + 1;
    localparam int DEN_W  = ADC_BITS + ntc_pkg::NOM_W;
    localparam int LG_SW  = $bits(ntc_pkg::t_lg_side);
    localparam int D1_SW  = $bits(ntc_pkg::t_d1_side);
    localparam int D2_SW  = $bits(ntc_pkg::t_d2_side);
    localparam int STEPS  = ntc_pkg::LOG_STEPS;
    localparam int Q1     = ntc_pkg::Q1_W;
    localparam int Q2     = ntc_pkg::Q2_W;
    localparam int BW     = ntc_pkg::BETA_W;
    localparam int ITW    = ntc_pkg::IT_W;

    // ---------------- configuration registers ----------------
    logic [ntc_pkg::SER_W-1:0]  r_series;
    logic [ntc_pkg::NOM_W-1:0]  r_nominal;
    logic [BW-1:0]              r_beta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_series  <= ntc_pkg::SER_W'(4700);
            r_nominal <= ntc_pkg::NOM_W'(10000);
            r_beta    <= BW'(3380);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                ntc_pkg::CFG_SERIES:  r_series  <= i_cfg_wdata[ntc_pkg::SER_W-1:0];
                ntc_pkg::CFG_NOMINAL: r_nominal <= i_cfg_wdata[ntc_pkg::NOM_W-1:0];
                ntc_pkg::CFG_BETA:    r_beta    <= i_cfg_wdata[BW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline advance ----------------
    // the whole row moves unless the skid stage is holding a word
    logic w_en;
    logic r_k_v;
    assign w_en    = !r_k_v;
    assign o_stall = r_k_v;

    // ---------------- stage: multipliers ----------------
    logic                r_mul_v;
    logic                r_mul_zero;
    logic [NUM_W-1:0]    r_mul_num;
    logic [DEN_W-1:0]    r_mul_den;
    logic [ADC_BITS:0]   w_rem_code;

    // resistance ratio as num / den = series * (full - code) / (code * nominal)
    assign w_rem_code = {1'b1, {ADC_BITS{1'b0}}} - {1'b0, i_adc_code};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_v <= 1'b0;
        end else if (w_en) begin
            r_mul_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mul_zero <= (i_adc_code == '0);
            r_mul_num  <= NUM_W'(r_series) * NUM_W'(w_rem_code);
            r_mul_den  <= DEN_W'(i_adc_code) * DEN_W'(r_nominal);
        end
    end

    // ---------------- stage: leading one search and special cases ----------------
    logic [ntc_pkg::E_W-1:0] w_e_num, w_e_den;
    ntc_pkg::t_flags         w_fl_lz;

    always_comb begin
        w_e_num = '0;
        for (int i = 0; i < NUM_W; i++) begin
            if (r_mul_num[i]) begin
                w_e_num = ntc_pkg::E_W'(i);
            end
        end
        w_e_den = '0;
        for (int i = 0; i < DEN_W; i++) begin
            if (r_mul_den[i]) begin
                w_e_den = ntc_pkg::E_W'(i);
            end
        end
    end

    always_comb begin
        w_fl_lz.forced = 1'b1;
        if (r_mul_zero) begin
            w_fl_lz.st = ntc_pkg::ST_INVALID;
        end else if (r_mul_num == '0) begin
            // zero resistance reads as hottest
            w_fl_lz.st = ntc_pkg::ST_HIGH;
        end else if (r_mul_den == '0) begin
            w_fl_lz.st = ntc_pkg::ST_LOW;
        end else begin
            w_fl_lz.forced = 1'b0;
            w_fl_lz.st     = ntc_pkg::ST_OK;
        end
    end

    logic                    r_lz_v;
    logic [NUM_W-1:0]        r_lz_num;
    logic [DEN_W-1:0]        r_lz_den;
    ntc_pkg::t_lg_side       r_lz_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lz_v <= 1'b0;
        end else if (w_en) begin
            r_lz_v <= r_mul_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lz_num        <= r_mul_num;
            r_lz_den        <= r_mul_den;
            r_lz_side.e_num <= w_e_num;
            r_lz_side.e_den <= w_e_den;
            r_lz_side.fl    <= w_fl_lz;
        end
    end

    // ---------------- stage: normalize mantissas to q1.31 ----------------
    logic [NUM_W+ntc_pkg::MANT_W-2:0] w_sh_num;
    logic [DEN_W+ntc_pkg::MANT_W-2:0] w_sh_den;

    assign w_sh_num = {r_lz_num, {(ntc_pkg::MANT_W-1){1'b0}}} >> r_lz_side.e_num;
    assign w_sh_den = {r_lz_den, {(ntc_pkg::MANT_W-1){1'b0}}} >> r_lz_side.e_den;

    logic                       w_lg_v    [0:STEPS];
    logic [ntc_pkg::MANT_W-1:0] w_lg_ma   [0:STEPS];
    logic [ntc_pkg::FRAC_W-1:0] w_lg_fa   [0:STEPS];
    logic [ntc_pkg::MANT_W-1:0] w_lg_mb   [0:STEPS];
    logic [ntc_pkg::FRAC_W-1:0] w_lg_fb   [0:STEPS];
    logic [LG_SW-1:0]           w_lg_side [0:STEPS];

    logic                       r_nrm_v;
    logic [ntc_pkg::MANT_W-1:0] r_nrm_ma, r_nrm_mb;
    ntc_pkg::t_lg_side          r_nrm_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nrm_v <= 1'b0;
        end else if (w_en) begin
            r_nrm_v <= r_lz_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nrm_ma   <= w_sh_num[ntc_pkg::MANT_W-1:0];
            r_nrm_mb   <= w_sh_den[ntc_pkg::MANT_W-1:0];
            r_nrm_side <= r_lz_side;
        end
    end

    assign w_lg_v[0]    = r_nrm_v;
    assign w_lg_ma[0]   = r_nrm_ma;
    assign w_lg_fa[0]   = '0;
    assign w_lg_mb[0]   = r_nrm_mb;
    assign w_lg_fb[0]   = '0;
    assign w_lg_side[0] = r_nrm_side;

    // ---------------- log2 fraction: one bit per cell ----------------
    for (genvar g = 0; g < STEPS; g++) begin : g_log
        ntc_log_cell #(
            .PW (LG_SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_v     (w_lg_v[g]),
            .i_m_a   (w_lg_ma[g]),
            .i_f_a   (w_lg_fa[g]),
            .i_m_b   (w_lg_mb[g]),
            .i_f_b   (w_lg_fb[g]),
            .i_side  (w_lg_side[g]),
            .o_v     (w_lg_v[g+1]),
            .o_m_a   (w_lg_ma[g+1]),
            .o_f_a   (w_lg_fa[g+1]),
            .o_m_b   (w_lg_mb[g+1]),
            .o_f_b   (w_lg_fb[g+1]),
            .o_side  (w_lg_side[g+1])
        );
    end

    // ---------------- stage: log difference ----------------
    ntc_pkg::t_lg_side          w_lg_end;
    logic [ntc_pkg::LOG_W-1:0]  w_l_num, w_l_den;

    assign w_lg_end = w_lg_side[STEPS];
    assign w_l_num  = {w_lg_end.e_num, w_lg_fa[STEPS]};
    assign w_l_den  = {w_lg_end.e_den, w_lg_fb[STEPS]};

    logic                       r_sub_v;
    logic                       r_sub_neg;
    logic [ntc_pkg::LOG_W-1:0]  r_sub_abs;
    ntc_pkg::t_flags            r_sub_fl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_v <= 1'b0;
        end else if (w_en) begin
            r_sub_v <= w_lg_v[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sub_neg <= w_l_num < w_l_den;
            r_sub_abs <= (w_l_num < w_l_den) ? (w_l_den - w_l_num) : (w_l_num - w_l_den);
            r_sub_fl  <= w_lg_end.fl;
        end
    end

    // ---------------- stage: scale by ln 2 ----------------
    logic [2*ntc_pkg::LN_W-1:0] w_prod;
    logic [2*ntc_pkg::LN_W-1:0] w_prod_rnd;

    assign w_prod     = r_sub_abs * ntc_pkg::LN2_Q30;
    assign w_prod_rnd = w_prod + (2*ntc_pkg::LN_W)'(64'd1 << 29);

    logic                       r_ln_v;
    logic                       r_ln_neg;
    logic [ntc_pkg::LN_W-1:0]   r_ln_mag;
    ntc_pkg::t_flags            r_ln_fl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ln_v <= 1'b0;
        end else if (w_en) begin
            r_ln_v <= r_sub_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ln_neg <= r_sub_neg;
            r_ln_mag <= w_prod_rnd[2*ntc_pkg::LN_W-1:ntc_pkg::LN_W];
            r_ln_fl  <= r_sub_fl;
        end
    end

    // ---------------- stage: first divider setup ----------------
    // quotient past 42 bits means the pole (hot) or far below range (cold)
    logic [BW-1:0]              w_beta_eff;
    logic [ntc_pkg::D1_W-1:0]   w_d1;

    assign w_beta_eff = (r_beta == '0) ? BW'(1) : r_beta;
    assign w_d1       = {r_ln_mag, {ntc_pkg::FRAC_W{1'b0}}}
                      + ntc_pkg::D1_W'(w_beta_eff >> 1);

    logic                       w_d1_v    [0:Q1];
    logic [BW-1:0]              w_d1_rem  [0:Q1];
    logic [Q1-1:0]              w_d1_low  [0:Q1];
    logic [Q1-1:0]              w_d1_quot [0:Q1];
    logic [BW-1:0]              w_d1_div  [0:Q1];
    logic [D1_SW-1:0]           w_d1_side [0:Q1];

    logic                       r_dv_v;
    logic [BW-1:0]              r_dv_rem;
    logic [Q1-1:0]              r_dv_low;
    logic [BW-1:0]              r_dv_div;
    ntc_pkg::t_d1_side          r_dv_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v <= 1'b0;
        end else if (w_en) begin
            r_dv_v <= r_ln_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_rem       <= BW'(w_d1[ntc_pkg::D1_W-1:Q1]);
            r_dv_low       <= w_d1[Q1-1:0];
            r_dv_div       <= w_beta_eff;
            r_dv_side.neg  <= r_ln_neg;
            r_dv_side.qovf <= BW'(w_d1[ntc_pkg::D1_W-1:Q1]) >= w_beta_eff;
            r_dv_side.fl   <= r_ln_fl;
        end
    end

    assign w_d1_v[0]    = r_dv_v;
    assign w_d1_rem[0]  = r_dv_rem;
    assign w_d1_low[0]  = r_dv_low;
    assign w_d1_quot[0] = '0;
    assign w_d1_div[0]  = r_dv_div;
    assign w_d1_side[0] = r_dv_side;

    for (genvar g = 0; g < Q1; g++) begin : g_div1
        ntc_div_cell #(
            .DW (BW),
            .QW (Q1),
            .PW (D1_SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_v     (w_d1_v[g]),
            .i_rem   (w_d1_rem[g]),
            .i_low   (w_d1_low[g]),
            .i_quot  (w_d1_quot[g]),
            .i_div   (w_d1_div[g]),
            .i_side  (w_d1_side[g]),
            .o_v     (w_d1_v[g+1]),
            .o_rem   (w_d1_rem[g+1]),
            .o_low   (w_d1_low[g+1]),
            .o_quot  (w_d1_quot[g+1]),
            .o_div   (w_d1_div[g+1]),
            .o_side  (w_d1_side[g+1])
        );
    end

    // ---------------- stage: 1/T ----------------
    ntc_pkg::t_d1_side          w_d1_end;
    logic signed [ITW:0]        w_inv_t;
    ntc_pkg::t_flags            w_fl_it;

    assign w_d1_end = w_d1_side[Q1];

    always_comb begin
        if (w_d1_end.neg) begin
            w_inv_t = $signed((ITW+1)'(ntc_pkg::INV_T0_Q48))
                    - $signed((ITW+1)'(w_d1_quot[Q1]));
        end else begin
            w_inv_t = $signed((ITW+1)'(ntc_pkg::INV_T0_Q48))
                    + $signed((ITW+1)'(w_d1_quot[Q1]));
        end
        w_fl_it = w_d1_end.fl;
        if (!w_d1_end.fl.forced) begin
            if (w_d1_end.qovf && !w_d1_end.neg) begin
                w_fl_it.forced = 1'b1;
                w_fl_it.st     = ntc_pkg::ST_LOW;
            end else if (w_d1_end.qovf || w_inv_t <= 0) begin
                // past the pole
                w_fl_it.forced = 1'b1;
                w_fl_it.st     = ntc_pkg::ST_HIGH;
            end
        end
    end

    logic                       r_it_v;
    logic [ITW-1:0]             r_it_inv;
    ntc_pkg::t_flags            r_it_fl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it_v <= 1'b0;
        end else if (w_en) begin
            r_it_v <= w_d1_v[Q1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_it_inv <= w_inv_t[ITW-1:0];
            r_it_fl  <= w_fl_it;
        end
    end

    // ---------------- stage: second divider setup ----------------
    logic [ntc_pkg::D2_W-1:0]   w_d2;
    logic [ITW-1:0]             w_d2_hi;

    assign w_d2    = ntc_pkg::TK_NUM + ntc_pkg::D2_W'(r_it_inv >> 1);
    assign w_d2_hi = ITW'(w_d2[ntc_pkg::D2_W-1:Q2]);

    logic                       w_d2_v    [0:Q2];
    logic [ITW-1:0]             w_d2_rem  [0:Q2];
    logic [Q2-1:0]              w_d2_low  [0:Q2];
    logic [Q2-1:0]              w_d2_quot [0:Q2];
    logic [ITW-1:0]             w_d2_div  [0:Q2];
    logic [D2_SW-1:0]           w_d2_side [0:Q2];

    logic                       r_d2_v;
    logic [ITW-1:0]             r_d2_rem;
    logic [Q2-1:0]              r_d2_low;
    logic [ITW-1:0]             r_d2_div;
    ntc_pkg::t_d2_side          r_d2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d2_v <= 1'b0;
        end else if (w_en) begin
            r_d2_v <= r_it_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2_rem      <= w_d2_hi;
            r_d2_low      <= w_d2[Q2-1:0];
            r_d2_div      <= r_it_inv;
            // kelvin reading of 655.36 or more is clamped high
            r_d2_side.ovf <= w_d2_hi >= r_it_inv;
            r_d2_side.fl  <= r_it_fl;
        end
    end

    assign w_d2_v[0]    = r_d2_v;
    assign w_d2_rem[0]  = r_d2_rem;
    assign w_d2_low[0]  = r_d2_low;
    assign w_d2_quot[0] = '0;
    assign w_d2_div[0]  = r_d2_div;
    assign w_d2_side[0] = r_d2_side;

    for (genvar g = 0; g < Q2; g++) begin : g_div2
        ntc_div_cell #(
            .DW (ITW),
            .QW (Q2),
            .PW (D2_SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_v     (w_d2_v[g]),
            .i_rem   (w_d2_rem[g]),
            .i_low   (w_d2_low[g]),
            .i_quot  (w_d2_quot[g]),
            .i_div   (w_d2_div[g]),
            .i_side  (w_d2_side[g]),
            .o_v     (w_d2_v[g+1]),
            .o_rem   (w_d2_rem[g+1]),
            .o_low   (w_d2_low[g+1]),
            .o_quot  (w_d2_quot[g+1]),
            .o_div   (w_d2_div[g+1]),
            .o_side  (w_d2_side[g+1])
        );
    end

    // ---------------- stage: celsius and clamping ----------------
    ntc_pkg::t_d2_side                 w_d2_end;
    logic signed [16:0]                w_c;
    logic [1:0]                        w_st;
    logic signed [ntc_pkg::TEMP_W-1:0] w_temp;

    assign w_d2_end = w_d2_side[Q2];
    assign w_c      = $signed({1'b0, w_d2_quot[Q2]}) - ntc_pkg::K_OFFSET;

    always_comb begin
        if (w_d2_end.fl.forced) begin
            w_st = w_d2_end.fl.st;
        end else if (w_d2_end.ovf || w_c > ntc_pkg::C_MAX) begin
            w_st = ntc_pkg::ST_HIGH;
        end else if (w_c < ntc_pkg::C_MIN) begin
            w_st = ntc_pkg::ST_LOW;
        end else begin
            w_st = ntc_pkg::ST_OK;
        end
        case (w_st)
            ntc_pkg::ST_OK:      w_temp = w_c[ntc_pkg::TEMP_W-1:0];
            ntc_pkg::ST_LOW:     w_temp = ntc_pkg::TEMP_MIN;
            ntc_pkg::ST_HIGH:    w_temp = ntc_pkg::TEMP_MAX;
            default:             w_temp = '0;
        endcase
    end

    logic                              r_fin_v;
    logic signed [ntc_pkg::TEMP_W-1:0] r_fin_temp;
    logic [1:0]                        r_fin_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
        end else if (w_en) begin
            r_fin_v <= w_d2_v[Q2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin_temp <= w_temp;
            r_fin_st   <= w_st;
        end
    end

    // ---------------- output register and skid ----------------
    // a word leaving the row goes to the output register when it is free,
    // otherwise into the skid, which then freezes the row
    logic                              r_o_v;
    logic signed [ntc_pkg::TEMP_W-1:0] r_o_temp, r_k_temp;
    logic [1:0]                        r_o_st, r_k_st;
    logic                              n_o_v, n_k_v;
    logic                              w_take, w_o_free;
    logic                              w_ld_o_pipe, w_ld_o_skid, w_ld_k;

    assign w_take   = r_o_v && !i_stall;
    assign w_o_free = !r_o_v || w_take;

    always_comb begin
        n_o_v       = r_o_v;
        n_k_v       = r_k_v;
        w_ld_o_pipe = 1'b0;
        w_ld_o_skid = 1'b0;
        w_ld_k      = 1'b0;
        if (r_k_v) begin
            if (w_take) begin
                w_ld_o_skid = 1'b1;
                n_k_v       = 1'b0;
            end
        end else if (r_fin_v) begin
            if (w_o_free) begin
                w_ld_o_pipe = 1'b1;
                n_o_v       = 1'b1;
            end else begin
                w_ld_k = 1'b1;
                n_k_v  = 1'b1;
            end
        end else if (w_take) begin
            n_o_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_k_v <= 1'b0;
        end else begin
            r_o_v <= n_o_v;
            r_k_v <= n_k_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_o_pipe) begin
            r_o_temp <= r_fin_temp;
            r_o_st   <= r_fin_st;
        end else if (w_ld_o_skid) begin
            r_o_temp <= r_k_temp;
            r_o_st   <= r_k_st;
        end
        if (w_ld_k) begin
            r_k_temp <= r_fin_temp;
            r_k_st   <= r_fin_st;
        end
    end

    assign o_valid        = r_o_v;
    assign o_temp_centi_c = r_o_temp;
    assign o_status       = r_o_st;

endmodule
